// File: rtl/assert_macros.svh
// Assertion macros used by the RTL top level of the digit stack block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CHK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: rtl/rcds_pkg.sv
// Package with constants and types of the radix conversion digit stack.
package rcds_pkg;

   localparam int VALUE_BITS    = 31;
   localparam int STACK_DEPTH   = 32;
   localparam int RADIX_BITS    = 4;
   localparam int DIGIT_BITS    = 4;
   localparam int RADIX_MIN     = 2;
   localparam int RADIX_MAX     = 10;
   localparam int CNT_BITS      = $clog2(STACK_DEPTH + 1);
   localparam int IDX_BITS      = $clog2(STACK_DEPTH);
   localparam int DIV_CNT_BITS  = $clog2(VALUE_BITS);
   localparam int REQ_DATA_BITS = ((VALUE_BITS + RADIX_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((DIGIT_BITS + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_POP_REQ,
      ST_POP_LOAD,
      ST_ERR
   } state_type;

   // Status the divider hands back to the sequencer.
   typedef struct packed {
      logic done;
      logic busy;
      logic quot_nz;
   } div_stat_type;

endpackage

// File: rtl/rcds_div.sv
// Bit-serial restoring divider of the value by a small radix.
module rcds_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [rcds_pkg::VALUE_BITS-1:0]   dividend,
   input  logic [rcds_pkg::RADIX_BITS-1:0]   radix,
   output logic [rcds_pkg::VALUE_BITS-1:0]   quotient,
   output logic [rcds_pkg::DIGIT_BITS-1:0]   remainder,
   output rcds_pkg::div_stat_type            stat
);
   import rcds_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    nz_ff, nz_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0]   quot_ff, quot_in;
   logic [DIGIT_BITS-1:0]   rem_ff, rem_in;
   logic [DIGIT_BITS:0]     trial;
   logic                    fits;

   // One quotient bit per cycle: the dividend shifts out at the top while
   // the quotient bits shift in at the bottom of the same register.
   assign trial = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign fits  = trial >= {1'b0, radix};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      nz_in   = nz_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         nz_in   = 1'b0;
         cnt_in  = DIV_CNT_BITS'(VALUE_BITS - 1);
         quot_in = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[VALUE_BITS-2:0], fits};
         rem_in  = fits ? DIGIT_BITS'(trial - {1'b0, radix}) : trial[DIGIT_BITS-1:0];
         nz_in   = nz_ff | fits;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         nz_ff   <= 1'b0;
         cnt_ff  <= '0;
         quot_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         nz_ff   <= nz_in;
         cnt_ff  <= cnt_in;
         quot_ff <= quot_in;
      end
      rem_ff <= rem_in;
   end

   assign quotient     = quot_ff;
   assign remainder    = rem_ff;
   assign stat.done    = done_ff;
   assign stat.busy    = busy_ff;
   assign stat.quot_nz = nz_ff;

endmodule

// File: rtl/radix_conversion_digit_stack_top.sv
// Top level of the radix conversion digit stack: sequencer, divider, stack and output register.
//
//   channel | direction | tdata                         | tuser     | tlast
//   req_    | in        | value[30:0], radix[34:31]     | -         | -
//   rsp_    | out       | digit[3:0]                    | bad_radix | last_digit
//
// Each digit costs one pass of the bit-serial divider, one bit of the value per cycle.
// Each popped digit passes through POP_REQ and POP_LOAD because the stack memory read is registered.
// One item is in work at a time.
// Reset is synchronous and clears the sequencer, the counters and the output valid.
// A stalled rsp_tready holds the pop; req_tready is high only between items.
module radix_conversion_digit_stack_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rcds_pkg::REQ_DATA_BITS-1:0]  req_tdata,   // value, radix, zero fill
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rcds_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,   // digit, zero fill
   output logic                                rsp_tlast,
   output logic                                rsp_tuser    // bad_radix
);
   import rcds_pkg::*;

   `include "assert_macros.svh"

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [RADIX_BITS-1:0]   radix_ff, radix_in;
   logic                    out_valid_ff, out_valid_in;
   logic [DIGIT_BITS-1:0]   out_digit_ff, out_digit_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_bad_ff, out_bad_in;

   logic [DIGIT_BITS-1:0]   stack_mem [STACK_DEPTH];
   logic [DIGIT_BITS-1:0]   rd_data_ff;
   logic                    stack_we, stack_re;
   logic [IDX_BITS-1:0]     stack_waddr, stack_raddr;

   logic                    div_start;
   logic [VALUE_BITS-1:0]   div_dividend;
   logic [VALUE_BITS-1:0]   div_quot;
   logic [DIGIT_BITS-1:0]   div_rem;
   div_stat_type            div_stat;

   logic [VALUE_BITS-1:0]   in_value;
   logic [RADIX_BITS-1:0]   in_radix;
   logic                    accept;
   logic                    out_free;

   assign in_value = req_tdata[VALUE_BITS-1:0];
   assign in_radix = req_tdata[VALUE_BITS+RADIX_BITS-1:VALUE_BITS];
   assign accept   = req_tvalid && req_tready;
   assign out_free = !out_valid_ff || rsp_tready;

   rcds_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (radix_ff),
      .quotient  (div_quot),
      .remainder (div_rem),
      .stat      (div_stat)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      radix_in     = radix_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_digit_in = out_digit_ff;
      out_last_in  = out_last_ff;
      out_bad_in   = out_bad_ff;
      req_tready   = 1'b0;
      div_start    = 1'b0;
      div_dividend = div_quot;
      stack_we     = 1'b0;
      stack_re     = 1'b0;
      stack_waddr  = count_ff[IDX_BITS-1:0];
      stack_raddr  = IDX_BITS'(count_ff - 1'b1);
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               if (in_radix < RADIX_BITS'(RADIX_MIN)) begin
                  state_in = ST_ERR;
               end else begin
                  radix_in = (in_radix > RADIX_BITS'(RADIX_MAX)) ?
                             RADIX_BITS'(RADIX_MAX) : in_radix;
                  count_in     = '0;
                  div_start    = 1'b1;
                  div_dividend = in_value;
                  state_in     = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               // Remainders beyond the stack depth are dropped.
               if (count_ff < CNT_BITS'(STACK_DEPTH)) begin
                  stack_we = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (div_stat.quot_nz) begin
                  div_start = 1'b1;
               end else begin
                  state_in = ST_POP_REQ;
               end
            end
         end
         ST_POP_REQ: begin
            stack_re = 1'b1;
            count_in = count_ff - 1'b1;
            state_in = ST_POP_LOAD;
         end
         ST_POP_LOAD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_digit_in = rd_data_ff;
               out_last_in  = (count_ff == '0);
               out_bad_in   = 1'b0;
               state_in     = (count_ff == '0) ? ST_IDLE : ST_POP_REQ;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_digit_in = '0;
               out_last_in  = 1'b1;
               out_bad_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         radix_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         radix_ff     <= radix_in;
         out_valid_ff <= out_valid_in;
      end
      out_digit_ff <= out_digit_in;
      out_last_ff  <= out_last_in;
      out_bad_ff   <= out_bad_in;
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= div_rem;
      end
      if (stack_re) begin
         rd_data_ff <= stack_mem[stack_raddr];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(out_digit_ff);
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_bad_ff;

   `ASSERT_CHK(a_done_in_div, div_stat.done |-> state_ff == ST_DIV, "divider done outside DIV")
   `ASSERT_NEVER(a_count_range, count_ff > CNT_BITS'(STACK_DEPTH), "digit count past depth")
   `ASSERT_CHK(a_idle_empty, state_ff == ST_IDLE |-> count_ff == '0 && !div_stat.busy, "idle with work left")
   `ASSERT_CHK(a_bad_form, rsp_tvalid && rsp_tuser |-> rsp_tlast && out_digit_ff == '0, "malformed error transfer")

endmodule

// File: verif/radix_conversion_digit_stack_top_tb.sv
// Self-checking testbench for the radix conversion digit stack with a built-in digit predictor.
`timescale 1ns / 1ps

module radix_conversion_digit_stack_top_tb;
   import rcds_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 1200;

   typedef struct packed {
      logic [DIGIT_BITS-1:0] digit;
      logic                  last_digit;
      logic                  bad_radix;
   } digit_rsp_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;
   logic                     rsp_tuser;

   digit_rsp_type digit_queue[$];
   int            fail_count;
   int            send_idle_pct;
   int            recv_stall_pct;
   int            hold_off_len;
   int            quiet_cycles;

   radix_conversion_digit_stack_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Converts one number the way the block should and queues its digits, top digit first.
   function automatic void predict_digits(input logic [VALUE_BITS-1:0] value,
                                          input logic [RADIX_BITS-1:0] radix);
      logic [DIGIT_BITS-1:0] stack [STACK_DEPTH];
      int unsigned           depth;
      logic [VALUE_BITS-1:0] quotient;
      logic [RADIX_BITS-1:0] base;
      digit_rsp_type         item;
      if (radix < RADIX_MIN) begin
         item.digit      = '0;
         item.last_digit = 1'b1;
         item.bad_radix  = 1'b1;
         digit_queue.push_back(item);
         return;
      end
      base     = (radix > RADIX_MAX) ? RADIX_BITS'(RADIX_MAX) : radix;
      quotient = value;
      depth    = 0;
      // A zero value still produces one remainder, so a do-while covers it.
      do begin
         if (depth < STACK_DEPTH) begin
            stack[depth] = DIGIT_BITS'(quotient % base);
            depth++;
         end
         quotient = quotient / base;
      end while (quotient != 0);
      while (depth > 0) begin
         depth--;
         item.digit      = stack[depth];
         item.last_digit = (depth == 0);
         item.bad_radix  = 1'b0;
         digit_queue.push_back(item);
      end
   endfunction

   // Called right after a rising edge; returns right after the edge of the transfer.
   task automatic send_number(input logic [VALUE_BITS-1:0] value,
                              input logic [RADIX_BITS-1:0] radix);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'({radix, value});
      do begin
         @(posedge clock);
      end while (!req_tready);
      predict_digits(value, radix);
   endtask

   task automatic send_random_number();
      int unsigned           sel;
      int unsigned           len;
      logic [RADIX_BITS-1:0] radix;
      logic [VALUE_BITS-1:0] value;
      sel = $urandom_range(99);
      if (sel < 6)
         radix = RADIX_BITS'($urandom_range(RADIX_MIN - 1, 0));
      else if (sel < 14)
         radix = RADIX_BITS'($urandom_range((1 << RADIX_BITS) - 1, RADIX_MAX + 1));
      else
         radix = RADIX_BITS'($urandom_range(RADIX_MAX, RADIX_MIN));
      // Random bit length keeps the digit count spread instead of always near the maximum.
      len   = $urandom_range(VALUE_BITS, 1);
      value = VALUE_BITS'($urandom() & ((32'h1 << len) - 1));
      send_number(value, radix);
   endtask

   // The last item has been transferred, so the offer is withdrawn before waiting.
   task automatic wait_for_digits();
      req_tvalid <= 1'b0;
      while (digit_queue.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_directed_cases();
      logic [VALUE_BITS-1:0] max_value;
      max_value = '1;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_number('0, RADIX_BITS'(10));
      send_number('0, RADIX_BITS'(2));
      send_number(max_value, RADIX_BITS'(2));
      send_number(max_value, RADIX_BITS'(10));
      send_number(max_value, RADIX_BITS'(3));
      send_number(VALUE_BITS'(1), RADIX_BITS'(2));
      send_number(VALUE_BITS'(10), RADIX_BITS'(10));
      send_number(VALUE_BITS'(9), RADIX_BITS'(10));
      send_number(VALUE_BITS'(12345), RADIX_BITS'(0));
      send_number(max_value, RADIX_BITS'(1));
      send_number('0, RADIX_BITS'(1));
      send_number(VALUE_BITS'(987654321), RADIX_BITS'(11));
      send_number(max_value, RADIX_BITS'(15));
      send_number(VALUE_BITS'(31'h2AAAAAAA), RADIX_BITS'(4));
      send_number(VALUE_BITS'(31'h55555555), RADIX_BITS'(5));
      send_number(VALUE_BITS'(1000000), RADIX_BITS'(6));
      send_number(VALUE_BITS'(823542), RADIX_BITS'(7));
      send_number(VALUE_BITS'(16777216), RADIX_BITS'(8));
      send_number(VALUE_BITS'(43046720), RADIX_BITS'(9));
      send_number(VALUE_BITS'(31'h40000000), RADIX_BITS'(2));
      wait_for_digits();
   endtask

   task automatic test_random_phase(input int items, input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (items)
         send_random_number();
   endtask

   // The receiver blocks for a long stretch while items keep coming, so the input stalls.
   task automatic test_output_hold_off();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_len   = 3000;
      send_number('1, RADIX_BITS'(2));
      repeat (5)
         send_random_number();
      wait_for_digits();
   endtask

   task automatic test_drain_pause();
      send_idle_pct  = 13;
      recv_stall_pct = 13;
      repeat (3)
         send_random_number();
      wait_for_digits();
      repeat (3)
         send_random_number();
   endtask

   // Receiver side: random stalls, or a long hold-off when one is requested.
   initial begin
      int hold_cnt;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_len > 0) begin
            rsp_tready   <= 1'b0;
            hold_cnt     = hold_off_len;
            hold_off_len = 0;
            while (hold_cnt > 0) begin
               @(posedge clock);
               hold_cnt--;
            end
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic void check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, expected, actual);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      digit_rsp_type exp_item;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digit_queue.size() == 0) begin
            $display("%0t: unexpected digit transfer: expected none, got digit %0d last %0b bad %0b",
                     $time, rsp_tdata[DIGIT_BITS-1:0], rsp_tlast, rsp_tuser);
            fail_count++;
         end else begin
            exp_item = digit_queue.pop_front();
            check_field("digit", exp_item.digit, rsp_tdata[DIGIT_BITS-1:0]);
            check_field("last_digit", exp_item.last_digit, rsp_tlast);
            check_field("bad_radix", exp_item.bad_radix, rsp_tuser);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d digits outstanding",
                  $time, quiet_cycles, digit_queue.size());
         $display("radix_conversion_digit_stack_top_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      fail_count     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_len   = 0;
      quiet_cycles   = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_phase(100, 0, 0);
      test_random_phase(100, 45, 0);
      test_output_hold_off();
      test_random_phase(100, 0, 45);
      test_drain_pause();
      test_random_phase(100, 13, 13);

      wait_for_digits();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("radix_conversion_digit_stack_top_tb: done, clean");
      else
         $display("radix_conversion_digit_stack_top_tb: done, errors");
      $finish;
   end

endmodule

// File: radix_conversion_digit_stack_top.f
+incdir+rtl
rtl/rcds_pkg.sv
rtl/rcds_div.sv
rtl/radix_conversion_digit_stack_top.sv
verif/radix_conversion_digit_stack_top_tb.sv
